// File: rtl/urspwm_pkg.sv
// Shared types and constants for the ultrasonic ranger and servo PWM block.
package urspwm_pkg;

  // Width of the echo tick counter; the counter saturates at its top value.
  localparam int COUNT_WIDTH = 16;

  // distance_mm = 340 * (2 * count) / 1000 = 17 * count / 25
  localparam int DIST_NUM   = 17;
  localparam int DIST_DEN   = 25;
  localparam int REM_WIDTH  = $clog2(DIST_DEN);

  localparam logic [15:0] PWM_PERIOD_RST    = 16'd4999;
  localparam logic [7:0]  TRIGGER_TICKS_RST = 8'd3;
  localparam logic [15:0] GAP_TICKS_RST     = 16'd25000;
  localparam logic [15:0] PULSE_RST         = 16'd375;

  // Distance bands and the servo pulse for each band
  localparam logic [15:0] BAND_0 = 16'd100;
  localparam logic [15:0] BAND_1 = 16'd200;
  localparam logic [15:0] BAND_2 = 16'd300;
  localparam logic [15:0] BAND_3 = 16'd400;
  localparam logic [15:0] BAND_4 = 16'd500;
  localparam logic [15:0] PULSE_0 = 16'd500;
  localparam logic [15:0] PULSE_1 = 16'd438;
  localparam logic [15:0] PULSE_2 = 16'd375;
  localparam logic [15:0] PULSE_3 = 16'd313;
  localparam logic [15:0] PULSE_4 = 16'd250;

  // Configuration register indexes
  localparam logic [1:0] REG_PWM_PERIOD    = 2'd0;
  localparam logic [1:0] REG_TRIGGER_TICKS = 2'd1;
  localparam logic [1:0] REG_GAP_TICKS     = 2'd2;

  typedef enum logic [2:0] {
    PH_TRIG_LOW  = 3'd0,
    PH_TRIG_HIGH = 3'd1,
    PH_WAIT_RISE = 3'd2,
    PH_MEASURE   = 3'd3,
    PH_GAP       = 3'd4
  } phase_t;

  typedef struct packed {
    logic [15:0] pwm_period;
    logic [7:0]  trigger_ticks;
    logic [15:0] gap_ticks;
  } cfg_t;

  // Sequencer results for one tick
  typedef struct packed {
    logic        trig;
    logic        done;
    logic [15:0] pulse_next;
    logic [15:0] distance_next;
  } seq_res_t;

endpackage

// File: rtl/ultrasonic_range_to_servo_pwm.sv
// Top level: ultrasonic ranger driving a servo PWM, one beat per 4 us tick.
//
//   channel   dir  signals                      beat content
//   s_*       in   s_tvalid s_tready s_tdata    one tick, echo level
//   m_*       out  m_tvalid m_tready m_tdata    pin levels and status for that tick
//   cfg_*     in   cfg_we cfg_index cfg_data    register write, no wait
//
// One beat per cycle sustained while m_tready holds; each beat passes an input
// register and one pass of sequencer and PWM logic into the output register.
// Synchronous reset restores defaults in all but in_echo, m_tdata, dist_q, dist_r.
// A stalled output holds its beat; the input register still takes one beat,
// then s_tready drops until the output drains.
module ultrasonic_range_to_servo_pwm import urspwm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] echo, [7:1] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [0] trig_out, [1] pwm_out, [17:2] pulse_ticks,
                                 // [33:18] distance_mm, [34] measure_done, [39:35] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t        cfg;
  logic        in_valid;
  logic        in_echo;
  logic        step;
  logic        pwm;
  logic [15:0] pulse_value;
  seq_res_t    res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pwm_period    <= PWM_PERIOD_RST;
      cfg.trigger_ticks <= TRIGGER_TICKS_RST;
      cfg.gap_ticks     <= GAP_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PWM_PERIOD:    cfg.pwm_period    <= cfg_data;
        REG_TRIGGER_TICKS: cfg.trigger_ticks <= cfg_data[7:0];
        REG_GAP_TICKS:     cfg.gap_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready)
      in_echo <= s_tdata[0];
  end

  urspwm_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .echo        (in_echo),
    .cfg         (cfg),
    .pulse_value (pulse_value),
    .res         (res)
  );

  // PWM sees the pulse as it stood before this tick's measurement
  urspwm_pwm u_pwm (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .pwm_period  (cfg.pwm_period),
    .pulse_value (pulse_value),
    .pwm         (pwm)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step)
      m_tdata <= {5'd0, res.done, res.distance_next, res.pulse_next, pwm, res.trig};
  end

endmodule

// File: rtl/urspwm_seq.sv
// Trigger / echo sequencer with running distance and servo pulse selection.
module urspwm_seq import urspwm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        echo,
  input  cfg_t        cfg,
  output logic [15:0] pulse_value,
  output seq_res_t    res
);

  phase_t                 phase, phase_next;
  logic [15:0]            phase_ticks, phase_ticks_next;
  logic [COUNT_WIDTH-1:0] echo_ticks, echo_ticks_next;
  logic [15:0]            dist_q, dist_q_next;
  logic [REM_WIDTH-1:0]   dist_r, dist_r_next;
  logic [15:0]            last_distance, last_distance_next;
  logic [15:0]            pulse_next;
  logic [16:0]            pt_inc;
  logic [15:0]            trig_len;
  logic [REM_WIDTH:0]     rem_sum;
  logic                   trig, done;

  assign trig_len = (cfg.trigger_ticks == 8'd0) ? 16'd1 : {8'd0, cfg.trigger_ticks};
  assign pt_inc   = {1'b0, phase_ticks} + 17'd1;
  assign rem_sum  = {1'b0, dist_r} + (REM_WIDTH+1)'(DIST_NUM);

  always_comb begin
    phase_next         = phase;
    phase_ticks_next   = phase_ticks;
    echo_ticks_next    = echo_ticks;
    dist_q_next        = dist_q;
    dist_r_next        = dist_r;
    last_distance_next = last_distance;
    pulse_next         = pulse_value;
    trig               = 1'b0;
    done               = 1'b0;
    case (phase)
      PH_TRIG_HIGH: begin
        trig = 1'b1;
        if (pt_inc >= {1'b0, trig_len}) begin
          phase_next       = PH_WAIT_RISE;
          phase_ticks_next = '0;
        end else begin
          phase_ticks_next = pt_inc[15:0];
        end
      end
      PH_WAIT_RISE: begin
        if (echo) begin
          echo_ticks_next = COUNT_WIDTH'(1);
          dist_q_next     = '0;
          dist_r_next     = REM_WIDTH'(DIST_NUM);
          phase_next      = PH_MEASURE;
        end
      end
      PH_MEASURE: begin
        if (echo) begin
          if (echo_ticks != {COUNT_WIDTH{1'b1}}) begin
            echo_ticks_next = echo_ticks + COUNT_WIDTH'(1);
            // quotient and remainder of 17*count/25 kept in step with count
            if (rem_sum >= (REM_WIDTH+1)'(DIST_DEN)) begin
              dist_r_next = REM_WIDTH'(rem_sum - (REM_WIDTH+1)'(DIST_DEN));
              if (dist_q != 16'hFFFF)
                dist_q_next = dist_q + 16'd1;
            end else begin
              dist_r_next = rem_sum[REM_WIDTH-1:0];
            end
          end
        end else begin
          done               = 1'b1;
          last_distance_next = dist_q;
          phase_ticks_next   = '0;
          phase_next         = (cfg.gap_ticks == 16'd0) ? PH_TRIG_LOW : PH_GAP;
          if (dist_q < BAND_0)      pulse_next = PULSE_0;
          else if (dist_q < BAND_1) pulse_next = PULSE_1;
          else if (dist_q < BAND_2) pulse_next = PULSE_2;
          else if (dist_q < BAND_3) pulse_next = PULSE_3;
          else if (dist_q < BAND_4) pulse_next = PULSE_4;
        end
      end
      PH_GAP: begin
        if (pt_inc >= {1'b0, cfg.gap_ticks}) begin
          phase_next       = PH_TRIG_LOW;
          phase_ticks_next = '0;
        end else begin
          phase_ticks_next = pt_inc[15:0];
        end
      end
      default: begin
        if (pt_inc >= {1'b0, trig_len}) begin
          phase_next       = PH_TRIG_HIGH;
          phase_ticks_next = '0;
        end else begin
          phase_next       = PH_TRIG_LOW;
          phase_ticks_next = pt_inc[15:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TRIG_LOW;
      phase_ticks   <= '0;
      echo_ticks    <= '0;
      last_distance <= '0;
      pulse_value   <= PULSE_RST;
    end else if (step) begin
      phase         <= phase_next;
      phase_ticks   <= phase_ticks_next;
      echo_ticks    <= echo_ticks_next;
      last_distance <= last_distance_next;
      pulse_value   <= pulse_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      dist_q <= dist_q_next;
      dist_r <= dist_r_next;
    end
  end

  assign res.trig          = trig;
  assign res.done          = done;
  assign res.pulse_next    = pulse_next;
  assign res.distance_next = last_distance_next;

endmodule

// File: rtl/urspwm_pwm.sv
// Servo PWM counter with the pulse width latched at period start.
module urspwm_pwm import urspwm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [15:0] pwm_period,
  input  logic [15:0] pulse_value,
  output logic        pwm
);

  logic [15:0] pwm_count, pwm_count_next;
  logic [15:0] active_pulse, active_pulse_next;

  always_comb begin
    active_pulse_next = (pwm_count == 16'd0) ? pulse_value : active_pulse;
    pwm               = (pwm_count <= active_pulse_next);
    // a count at or past the top wraps, also when the top was just lowered
    pwm_count_next    = (pwm_count >= pwm_period) ? 16'd0 : pwm_count + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_count    <= '0;
      active_pulse <= PULSE_RST;
    end else if (step) begin
      pwm_count    <= pwm_count_next;
      active_pulse <= active_pulse_next;
    end
  end

endmodule

// File: tb/ultrasonic_range_to_servo_pwm_test.sv
// Self-checking testbench for the ultrasonic ranger with servo PWM output.
`timescale 1ns / 100ps

module ultrasonic_range_to_servo_pwm_test;
  import urspwm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned ECHO_MAX    = (1 << COUNT_WIDTH) - 1;
  localparam int unsigned HOLD_CYCLES = 200;
  // first echo count that lands in each distance band (100..500 mm)
  localparam int unsigned BAND_START [5] = '{148, 295, 442, 589, 736};
  localparam logic [7:0]  RESET_ECHO    = 8'b10100101;
  // LSB first: end of a 1-tick echo, noise on trigger, 3-tick echo, 1-tick echo, noise
  localparam logic [13:0] DIRECTED_ECHO = 14'b11010001110110;

  typedef struct packed {
    logic        trig;
    logic        pwm;
    logic [15:0] pulse;
    logic [15:0] distance;
    logic        done;
  } tick_result_t;

  typedef struct {
    int unsigned period;
    int unsigned trig;
    int unsigned gap;
    int unsigned ticks;
    int unsigned idle;
    bit          hold;
  } setting_t;

  class range_scoreboard;
    logic [15:0]  pwm_period;
    logic [7:0]   trigger_ticks;
    logic [15:0]  gap_ticks;
    phase_t       phase;
    int unsigned  phase_ticks;
    int unsigned  echo_ticks;
    int unsigned  pwm_count;
    int unsigned  pulse_value;
    int unsigned  active_pulse;
    int unsigned  last_distance;
    tick_result_t awaited[$];
    int           errors;

    function new();
      pwm_period    = 16'd4999;
      trigger_ticks = 8'd3;
      gap_ticks     = 16'd25000;
      phase         = PH_TRIG_LOW;
      phase_ticks   = 0;
      echo_ticks    = 0;
      pwm_count     = 0;
      pulse_value   = 375;
      active_pulse  = 375;
      last_distance = 0;
      errors        = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_PWM_PERIOD:    pwm_period = val;
        REG_TRIGGER_TICKS: trigger_ticks = val[7:0];
        REG_GAP_TICKS:     gap_ticks = val;
        default: ;
      endcase
    endfunction

    // one tick in: PWM first, using the pulse from before this tick's measurement
    function void note_tick(logic lvl);
      tick_result_t r;
      int unsigned trig_len;
      longint unsigned dist_mm;
      r = '0;
      trig_len = (trigger_ticks == 0) ? 1 : trigger_ticks;
      if (pwm_count == 0) active_pulse = pulse_value;
      r.pwm = (pwm_count <= active_pulse);
      pwm_count = (pwm_count >= pwm_period) ? 0 : ((pwm_count + 1) & 32'hFFFF);
      case (phase)
        PH_TRIG_HIGH: begin
          r.trig = 1'b1;
          phase_ticks++;
          if (phase_ticks >= trig_len) begin
            phase = PH_WAIT_RISE;
            phase_ticks = 0;
          end
        end
        PH_WAIT_RISE: begin
          if (lvl) begin
            echo_ticks = 1;
            phase = PH_MEASURE;
          end
        end
        PH_MEASURE: begin
          if (lvl) begin
            if (echo_ticks < ECHO_MAX) echo_ticks++;
          end else begin
            dist_mm = (64'd340 * (64'(echo_ticks) * 64'd2)) / 64'd1000;
            if (dist_mm > 65535) dist_mm = 65535;
            last_distance = int'(dist_mm);
            if (dist_mm < 100) pulse_value = 500;
            else if (dist_mm < 200) pulse_value = 438;
            else if (dist_mm < 300) pulse_value = 375;
            else if (dist_mm < 400) pulse_value = 313;
            else if (dist_mm < 500) pulse_value = 250;
            r.done = 1'b1;
            phase_ticks = 0;
            phase = (gap_ticks == 0) ? PH_TRIG_LOW : PH_GAP;
          end
        end
        PH_GAP: begin
          phase_ticks++;
          if (phase_ticks >= gap_ticks) begin
            phase = PH_TRIG_LOW;
            phase_ticks = 0;
          end
        end
        default: begin
          phase_ticks++;
          if (phase_ticks >= trig_len) begin
            phase = PH_TRIG_HIGH;
            phase_ticks = 0;
          end else begin
            phase = PH_TRIG_LOW;
          end
        end
      endcase
      r.pulse    = pulse_value[15:0];
      r.distance = last_distance[15:0];
      awaited.push_back(r);
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_beat(logic [39:0] data);
      tick_result_t want;
      if (awaited.size() == 0) begin
        $error("output beat with no tick outstanding: %h", data);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare("trig_out", 16'(want.trig), 16'(data[0]));
      compare("pwm_out", 16'(want.pwm), 16'(data[1]));
      compare("pulse_ticks", want.pulse, data[17:2]);
      compare("distance_mm", want.distance, data[33:18]);
      compare("measure_done", 16'(want.done), 16'(data[34]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  range_scoreboard sb;
  int unsigned     idle_max = 3;
  int unsigned     high_left = 0;
  int unsigned     cycle_count = 0;
  bit              hold_req = 1'b0;

  setting_t plans [6] = '{
    '{99,    1,   5,     120, 15, 1'b0},
    '{600,   2,   0,     180, 15, 1'b1},
    '{65535, 3,   65535, 120, 7,  1'b0},
    '{20,    255, 1,     550, 15, 1'b0},
    '{700,   4,   3,     200, 15, 1'b0},
    '{300,   1,   2,     200, 0,  1'b1}
  };

  ultrasonic_range_to_servo_pwm uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // mostly short echoes, some straddling band edges, the odd long one
  function automatic int unsigned echo_len();
    int unsigned pick;
    int unsigned band_start;
    pick = $urandom_range(19, 0);
    if (pick < 15) return $urandom_range(24, 1);
    if (pick == 19) return $urandom_range(900, 1);
    band_start = BAND_START[(pick < 17) ? $urandom_range(1, 0) : $urandom_range(4, 2)];
    return band_start + $urandom_range(4, 0) - 2;
  endfunction

  // entered and left just after a falling edge
  task automatic send_tick(input logic lvl);
    int unsigned pause;
    pause = $urandom_range(idle_max, 0);
    if (pause != 0) begin
      s_tvalid <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, lvl};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_tick(lvl);
    @(negedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  // registers change only once the pipeline has drained
  task automatic apply_setting(input setting_t s);
    s_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    put_reg(REG_PWM_PERIOD, 16'(s.period));
    put_reg(REG_TRIGGER_TICKS, 16'(s.trig));
    put_reg(REG_GAP_TICKS, 16'(s.gap));
    cfg_we <= 1'b0;
    idle_max = s.idle;
    hold_req = s.hold;
  endtask

  // echo follows the predicted sequencer: well-formed pulses while waiting,
  // random noise while triggering or idling, rare early dropouts
  task automatic drive_ticks(input int unsigned count);
    logic lvl;
    for (int unsigned i = 0; i < count; i++) begin
      case (sb.phase)
        PH_WAIT_RISE: begin
          lvl = ($urandom_range(3, 0) != 0);
          if (lvl) high_left = echo_len() - 1;
        end
        PH_MEASURE: begin
          lvl = (high_left != 0) && ($urandom_range(63, 0) != 0);
          if (lvl) high_left--;
        end
        default: lvl = ($urandom_range(5, 0) == 0);
      endcase
      send_tick(lvl);
    end
  endtask

  initial begin : result_sink
    int unsigned pause;
    m_tready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        pause = HOLD_CYCLES;
      end else begin
        pause = $urandom_range(idle_max, 0);
      end
      if (pause != 0) begin
        m_tready <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_beat(m_tdata);
    end
  end

  initial begin : stimulus
    sb        = new();
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_PWM_PERIOD;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings, then period 0, trigger length 0 and zero gap
    for (int i = 0; i < 8; i++) send_tick(RESET_ECHO[i]);
    apply_setting('{0, 0, 0, 0, 3, 1'b0});
    for (int i = 0; i < 14; i++) send_tick(DIRECTED_ECHO[i]);

    foreach (plans[p]) begin
      apply_setting(plans[p]);
      drive_ticks(plans[p].ticks);
    end

    apply_setting('{65535, 1, 0, 0, 0, 1'b0});
    drive_ticks(20);

    s_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
